// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the top-level and histogram-bank RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ISC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle, outside reset.
`define ISC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

// ===== rtl/isc_pkg.sv =====
package isc_pkg;

    localparam int DEF_HIST_BINS  = 256;
    localparam int DEF_COUNT_BITS = 32;

    localparam int RUN_BITS    = 8;
    localparam int IDX_BITS    = 8;
    localparam int OUT_BITS    = 32;
    localparam int SUB_ENTRIES = 16;
    localparam int BASE_COUNT  = 4;

    localparam logic [2:0] SYM_STAR = 3'd4;
    localparam logic [2:0] SYM_GAP  = 3'd6;

    typedef enum logic [1:0] {
        TBL_INS = 2'd0,
        TBL_DEL = 2'd1,
        TBL_SUB = 2'd2,
        TBL_TOT = 2'd3
    } t_table_sel;

    localparam logic [IDX_BITS-1:0] TOT_INS      = 8'd0;
    localparam logic [IDX_BITS-1:0] TOT_DEL      = 8'd1;
    localparam logic [IDX_BITS-1:0] TOT_BASE_A   = 8'd2;
    localparam logic [IDX_BITS-1:0] TOT_BASE_END = 8'd6;

    typedef struct packed {
        logic valid;
        logic inc;
    } t_bank_req;

endpackage

// ===== rtl/indel_substitution_counter.sv =====
// Indel run-length histograms and substitution counts over aligned columns.
// Input channel (i_in_valid / o_in_ready): one item per cycle while o_in_ready is high. A column item
// (i_mode 0) carries a parent and child symbol and a last-column flag; a read
// item (i_mode 1) names a table and an entry.
// Output channel (o_out_valid / i_out_ready): one count per read item, in
// order, clamped to 32 bits. Column items give no result.
// Throughput: one item per cycle while o_in_ready is high. Each histogram is a
// RAM updated by registered read-modify-write, with the previous write forwarded.
// A read result passes the s1 registers and the RAM read register, then enters the output queue.
// Reset: runs, totals and substitution counters clear at once; both
// histogram RAMs are then swept to zero, one entry a cycle, over all
// HIST_BINS entries with o_in_ready low.
// Stall: a two-entry output queue holds results; o_in_ready drops in the reset sweep,
// else only while the queue plus the read in flight would overflow and the receiver stalls.
`include "assert_macros.svh"

module indel_substitution_counter import isc_pkg::*; #(
    parameter int HIST_BINS  = DEF_HIST_BINS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_mode,
    input  logic [2:0]          i_parent_code,
    input  logic [2:0]          i_child_code,
    input  logic                i_last_column,
    input  logic [1:0]          i_table_select,
    input  logic [IDX_BITS-1:0] i_read_index,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OUT_BITS-1:0] o_count_value
);

    localparam int AW = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
    localparam int CW = ((AW > IDX_BITS) ? AW : IDX_BITS) + 1;
    localparam logic [CW-1:0] TOP_BIN = CW'(HIST_BINS - 1);
    localparam logic [CW-1:0] BINS    = CW'(HIST_BINS);

    function automatic logic [AW-1:0] f_bin(input logic [RUN_BITS-1:0] run);
        logic [CW-1:0] wide;
        wide  = CW'(run);
        f_bin = (wide >= TOP_BIN) ? AW'(TOP_BIN) : AW'(wide);
    endfunction

    function automatic logic [COUNT_BITS-1:0] f_sat_inc(input logic [COUNT_BITS-1:0] v);
        f_sat_inc = (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [RUN_BITS-1:0] f_run_inc(input logic [RUN_BITS-1:0] v);
        f_run_inc = (&v) ? v : v + RUN_BITS'(1);
    endfunction

    function automatic logic [OUT_BITS-1:0] f_clamp(input logic [COUNT_BITS-1:0] v);
        logic [63:0] w;
        w       = 64'(v);
        f_clamp = (w > 64'h0000_0000_FFFF_FFFF) ? '1 : w[OUT_BITS-1:0];
    endfunction

    logic                  r_clearing;
    logic [AW-1:0]         r_clr_addr;

    logic [RUN_BITS-1:0]   r_ins_run;
    logic [RUN_BITS-1:0]   r_del_run;
    logic [RUN_BITS-1:0]   n_ins_run;
    logic [RUN_BITS-1:0]   n_del_run;
    logic [COUNT_BITS-1:0] r_ins_total;
    logic [COUNT_BITS-1:0] r_del_total;
    logic [COUNT_BITS-1:0] r_sub [SUB_ENTRIES];
    logic [COUNT_BITS-1:0] r_base [BASE_COUNT];

    logic                  r_s1_read;
    t_table_sel            r_s1_sel;
    logic                  r_s1_in_range;
    logic [COUNT_BITS-1:0] r_s1_direct;

    logic [OUT_BITS-1:0]   r_fifo [2];
    logic                  r_wp;
    logic                  r_rp;
    logic [1:0]            r_cnt;

    logic                  in_acc;
    logic                  col;
    logic                  pg;
    logic                  cg;
    logic                  ins_bin;
    logic                  del_bin;
    logic                  sub_hit;
    logic [3:0]            sub_idx;
    logic [1:0]            occ;
    logic                  pop;
    t_table_sel            sel;
    t_bank_req             ins_req;
    t_bank_req             del_req;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         ins_addr;
    logic [AW-1:0]         del_addr;
    logic                  rd_in_range;
    logic [COUNT_BITS-1:0] direct;
    logic [COUNT_BITS-1:0] ins_count;
    logic [COUNT_BITS-1:0] del_count;
    logic [COUNT_BITS-1:0] s1_value;
    logic [IDX_BITS-1:0]   base_off;

    assign sel         = t_table_sel'(i_table_select);
    assign pop         = o_out_valid && i_out_ready;
    assign occ         = r_cnt + {1'b0, r_s1_read};
    assign o_in_ready  = !r_clearing && ((occ < 2'd2) || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;
    assign col         = in_acc && !i_mode;
    assign pg          = (i_parent_code == SYM_GAP);
    assign cg          = (i_child_code == SYM_GAP);
    assign sub_idx     = {i_parent_code[1:0], i_child_code[1:0]};
    assign rd_addr     = AW'(i_read_index);
    assign rd_in_range = (CW'(i_read_index) < BINS);
    assign base_off    = i_read_index - TOT_BASE_A;

    always_comb begin
        n_ins_run = r_ins_run;
        n_del_run = r_del_run;
        ins_bin   = 1'b0;
        del_bin   = 1'b0;
        sub_hit   = 1'b0;
        if (col) begin
            unique case ({pg, cg})
                2'b11: begin
                end
                2'b01: begin
                    n_del_run = f_run_inc(r_del_run);
                    if (r_ins_run != '0) begin
                        ins_bin   = 1'b1;
                        n_ins_run = '0;
                    end
                end
                2'b10: begin
                    n_ins_run = f_run_inc(r_ins_run);
                    if (r_del_run != '0) begin
                        del_bin   = 1'b1;
                        n_del_run = '0;
                    end
                end
                default: begin
                    ins_bin   = 1'b1;
                    del_bin   = 1'b1;
                    n_ins_run = '0;
                    n_del_run = '0;
                    sub_hit   = (i_parent_code < SYM_STAR) && (i_child_code < SYM_STAR);
                end
            endcase
            if (i_last_column) begin
                n_ins_run = '0;
                n_del_run = '0;
            end
        end
    end

    always_comb begin
        ins_req.valid = in_acc && (i_mode ? (sel == TBL_INS) : ins_bin);
        ins_req.inc   = !i_mode;
        del_req.valid = in_acc && (i_mode ? (sel == TBL_DEL) : del_bin);
        del_req.inc   = !i_mode;
        ins_addr      = i_mode ? rd_addr : f_bin(r_ins_run);
        del_addr      = i_mode ? rd_addr : f_bin(r_del_run);
    end

    always_comb begin
        direct = '0;
        unique case (sel)
            TBL_SUB: begin
                if (i_read_index < IDX_BITS'(SUB_ENTRIES)) begin
                    direct = r_sub[i_read_index[3:0]];
                end
            end
            TBL_TOT: begin
                priority if (i_read_index == TOT_INS) begin
                    direct = r_ins_total;
                end else if (i_read_index == TOT_DEL) begin
                    direct = r_del_total;
                end else if (i_read_index < TOT_BASE_END) begin
                    direct = r_base[base_off[1:0]];
                end else begin
                    direct = '0;
                end
            end
            default: begin
                direct = '0;
            end
        endcase
    end

    isc_hist_bank #(
        .HIST_BINS  (HIST_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_ins_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (r_clearing),
        .i_clr_addr (r_clr_addr),
        .i_req      (ins_req),
        .i_addr     (ins_addr),
        .o_count    (ins_count)
    );

    isc_hist_bank #(
        .HIST_BINS  (HIST_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_del_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (r_clearing),
        .i_clr_addr (r_clr_addr),
        .i_req      (del_req),
        .i_addr     (del_addr),
        .o_count    (del_count)
    );

    always_comb begin
        unique case (r_s1_sel)
            TBL_INS: s1_value = r_s1_in_range ? ins_count : '0;
            TBL_DEL: s1_value = r_s1_in_range ? del_count : '0;
            default: s1_value = r_s1_direct;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_ins_run   <= '0;
            r_del_run   <= '0;
            r_ins_total <= '0;
            r_del_total <= '0;
            for (int k = 0; k < SUB_ENTRIES; k++) begin
                r_sub[k] <= '0;
            end
            for (int k = 0; k < BASE_COUNT; k++) begin
                r_base[k] <= '0;
            end
            r_s1_read   <= 1'b0;
            r_wp        <= 1'b0;
            r_rp        <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (r_clearing) begin
                if (r_clr_addr == AW'(HIST_BINS - 1)) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end
            r_ins_run <= n_ins_run;
            r_del_run <= n_del_run;
            if (ins_bin) begin
                r_ins_total <= f_sat_inc(r_ins_total);
            end
            if (del_bin) begin
                r_del_total <= f_sat_inc(r_del_total);
            end
            for (int k = 0; k < SUB_ENTRIES; k++) begin
                if (sub_hit && (sub_idx == 4'(k))) begin
                    r_sub[k] <= f_sat_inc(r_sub[k]);
                end
            end
            for (int k = 0; k < BASE_COUNT; k++) begin
                if (sub_hit && (i_parent_code[1:0] == 2'(k))) begin
                    r_base[k] <= f_sat_inc(r_base[k]);
                end
            end
            r_s1_read <= in_acc && i_mode;
            if (r_s1_read) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, r_s1_read} - {1'b0, pop};
        end
        if (in_acc) begin
            r_s1_sel      <= sel;
            r_s1_in_range <= rd_in_range;
            r_s1_direct   <= direct;
        end
        if (r_s1_read) begin
            r_fifo[r_wp] <= f_clamp(s1_value);
        end
    end

    assign o_out_valid   = (r_cnt != '0);
    assign o_count_value = r_fifo[r_rp];

    `ISC_ASSERT(a_occ_bound, i_clk, i_rst_n, ({1'b0, r_cnt} + {2'b00, r_s1_read}) <= 3'd2)
    `ISC_ASSERT(a_clear_end, i_clk, i_rst_n,
        $fell(r_clearing) |-> ($past(r_clr_addr) == AW'(HIST_BINS - 1)))
    `ISC_ASSERT(a_last_drops_runs, i_clk, i_rst_n,
        (col && i_last_column) |=> ((r_ins_run == '0) && (r_del_run == '0)))

endmodule

// ===== rtl/isc_ram.sv =====
module isc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/isc_hist_bank.sv =====
`include "assert_macros.svh"

module isc_hist_bank import isc_pkg::*; #(
    parameter int HIST_BINS  = DEF_HIST_BINS,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    localparam int AW = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clr,
    input  logic [AW-1:0]         i_clr_addr,
    input  t_bank_req             i_req,
    input  logic [AW-1:0]         i_addr,
    output logic [COUNT_BITS-1:0] o_count
);

    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] inc_val;
    logic [COUNT_BITS-1:0] wdata;
    logic                  we;
    logic [AW-1:0]         waddr;

    logic                  r_inc;
    logic [AW-1:0]         r_addr;
    logic                  r_fw_valid;
    logic [AW-1:0]         r_fw_addr;
    logic [COUNT_BITS-1:0] r_fw_data;

    isc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (HIST_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_req.valid),
        .i_raddr (i_addr),
        .o_rdata (ram_rdata)
    );

    // forward the write of the previous cycle, which the read did not see
    assign cur     = (r_fw_valid && (r_fw_addr == r_addr)) ? r_fw_data : ram_rdata;
    assign inc_val = (&cur) ? cur : cur + COUNT_BITS'(1);
    assign we      = i_clr || r_inc;
    assign waddr   = i_clr ? i_clr_addr : r_addr;
    assign wdata   = i_clr ? '0 : inc_val;
    assign o_count = cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc      <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            r_inc      <= i_req.valid && i_req.inc;
            r_fw_valid <= we;
        end
        if (i_req.valid) begin
            r_addr <= i_addr;
        end
        r_fw_addr <= waddr;
        r_fw_data <= wdata;
    end

    `ISC_ASSERT_IMP(a_no_req_in_clear, i_clk, i_rst_n, i_req.valid, !i_clr)
    `ISC_ASSERT_IMP(a_inc_in_clear, i_clk, i_rst_n, r_inc, !i_clr)
    `ISC_ASSERT(a_inc_follows_req, i_clk, i_rst_n, r_inc |-> $past(i_req.valid && i_req.inc))

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import isc_pkg::*;

    localparam int ITEM_TARGET = 1450;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic MODE_COLUMN = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    localparam logic [2:0] SYM_A     = 3'd0;
    localparam logic [2:0] SYM_C     = 3'd1;
    localparam logic [2:0] SYM_G     = 3'd2;
    localparam logic [2:0] SYM_T     = 3'd3;
    localparam logic [2:0] SYM_OTHER = 3'd5;
    localparam logic [2:0] SYM_SPARE = 3'd7;

    typedef struct packed {
        logic                mode;
        logic [2:0]          par;
        logic [2:0]          chi;
        logic                last;
        logic [1:0]          sel;
        logic [IDX_BITS-1:0] idx;
    } t_align_item;

    localparam int ITEM_BITS = $bits(t_align_item);

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_ready;
    logic                i_mode         = 1'b0;
    logic [2:0]          i_parent_code  = '0;
    logic [2:0]          i_child_code   = '0;
    logic                i_last_column  = 1'b0;
    logic [1:0]          i_table_select = '0;
    logic [IDX_BITS-1:0] i_read_index   = '0;
    logic                o_out_valid;
    logic                i_out_ready    = 1'b1;
    logic [OUT_BITS-1:0] o_count_value;

    indel_substitution_counter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_parent_code  (i_parent_code),
        .i_child_code   (i_child_code),
        .i_last_column  (i_last_column),
        .i_table_select (i_table_select),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_count_value  (o_count_value)
    );

    always #1 i_clk = ~i_clk;

    t_align_item         pending_items[$];
    logic [OUT_BITS-1:0] pending_counts[$];
    t_align_item         cur_item;

    logic [RUN_BITS-1:0] ins_run;
    logic [RUN_BITS-1:0] del_run;
    logic [31:0]         ins_hist [DEF_HIST_BINS];
    logic [31:0]         del_hist [DEF_HIST_BINS];
    logic [31:0]         sub_counts [SUB_ENTRIES];
    logic [31:0]         base_totals [BASE_COUNT];
    logic [31:0]         ins_total;
    logic [31:0]         del_total;

    int error_count = 0;
    int items_sent  = 0;
    int cycle_count = 0;
    int gap_left    = 0;
    int stall_left  = 0;

    task automatic report_mismatch(input string what, input logic [OUT_BITS-1:0] exp_val,
                                   input logic [OUT_BITS-1:0] got_val);
        begin
            $display("ERROR %0t: %s expected %h got %h", $realtime, what, exp_val, got_val);
            error_count++;
        end
    endtask

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    function automatic logic [RUN_BITS-1:0] run_inc(input logic [RUN_BITS-1:0] r);
        return (r == '1) ? r : r + RUN_BITS'(1);
    endfunction

    function automatic int bin_of(input logic [RUN_BITS-1:0] len);
        return (int'(len) < DEF_HIST_BINS - 1) ? int'(len) : DEF_HIST_BINS - 1;
    endfunction

    function automatic bit is_base(input logic [2:0] s);
        return int'(s) < BASE_COUNT;
    endfunction

    function automatic bit idling_allowed();
        return (items_sent < ITEM_TARGET * 9 / 10) && ((items_sent / 80) % 4 != 3);
    endfunction

    task automatic close_insertion();
        begin
            ins_hist[bin_of(ins_run)] = sat_inc(ins_hist[bin_of(ins_run)]);
            ins_total = sat_inc(ins_total);
            ins_run = '0;
        end
    endtask

    task automatic close_deletion();
        begin
            del_hist[bin_of(del_run)] = sat_inc(del_hist[bin_of(del_run)]);
            del_total = sat_inc(del_total);
            del_run = '0;
        end
    endtask

    task automatic update_tallies(input t_align_item it);
        logic [OUT_BITS-1:0] v;
        bit pg;
        bit cg;
        begin
            if (it.mode == MODE_READ) begin
                v = '0;
                case (t_table_sel'(it.sel))
                    TBL_INS: if (int'(it.idx) < DEF_HIST_BINS) v = ins_hist[it.idx];
                    TBL_DEL: if (int'(it.idx) < DEF_HIST_BINS) v = del_hist[it.idx];
                    TBL_SUB: if (int'(it.idx) < SUB_ENTRIES) v = sub_counts[it.idx[3:0]];
                    TBL_TOT: begin
                        if (it.idx == TOT_INS) v = ins_total;
                        else if (it.idx == TOT_DEL) v = del_total;
                        else if (it.idx < TOT_BASE_END) v = base_totals[int'(it.idx - TOT_BASE_A)];
                    end
                endcase
                pending_counts = {pending_counts, v};
            end else begin
                pg = (it.par == SYM_GAP);
                cg = (it.chi == SYM_GAP);
                if (pg && cg) begin
                end else if (!pg && cg) begin
                    del_run = run_inc(del_run);
                    if (ins_run != '0) close_insertion();
                end else if (pg && !cg) begin
                    ins_run = run_inc(ins_run);
                    if (del_run != '0) close_deletion();
                end else begin
                    close_insertion();
                    close_deletion();
                    if (is_base(it.par) && is_base(it.chi)) begin
                        sub_counts[{it.par[1:0], it.chi[1:0]}] =
                            sat_inc(sub_counts[{it.par[1:0], it.chi[1:0]}]);
                        base_totals[it.par[1:0]] = sat_inc(base_totals[it.par[1:0]]);
                    end
                end
                if (it.last) begin
                    ins_run = '0;
                    del_run = '0;
                end
            end
        end
    endtask

    task automatic push_column(input logic [2:0] par, input logic [2:0] chi, input logic last);
        t_align_item it;
        begin
            it.mode = MODE_COLUMN;
            it.par  = par;
            it.chi  = chi;
            it.last = last;
            it.sel  = 2'($urandom_range(0, 3));
            it.idx  = IDX_BITS'($urandom_range(0, 255));
            pending_items = {pending_items, it};
        end
    endtask

    task automatic push_read(input t_table_sel sel, input logic [IDX_BITS-1:0] idx);
        t_align_item it;
        begin
            it.mode = MODE_READ;
            it.par  = 3'($urandom_range(0, 7));
            it.chi  = 3'($urandom_range(0, 7));
            it.last = 1'($urandom_range(0, 1));
            it.sel  = sel;
            it.idx  = idx;
            pending_items = {pending_items, it};
        end
    endtask

    function automatic logic [2:0] rand_symbol();
        int r;
        r = $urandom_range(0, 19);
        if (r < 16) return 3'(r % 4);
        else if (r == 16) return SYM_STAR;
        else if (r == 17) return SYM_OTHER;
        else return SYM_SPARE;
    endfunction

    task automatic push_random_read();
        t_table_sel sel;
        logic [IDX_BITS-1:0] idx;
        begin
            sel = t_table_sel'($urandom_range(0, 3));
            case (sel)
                TBL_INS, TBL_DEL:
                    idx = ($urandom_range(0, 9) < 7) ? IDX_BITS'($urandom_range(0, 8))
                                                     : IDX_BITS'($urandom_range(0, 255));
                TBL_SUB:
                    idx = ($urandom_range(0, 19) < 17) ? IDX_BITS'($urandom_range(0, 15))
                                                       : IDX_BITS'($urandom_range(0, 255));
                default:
                    idx = ($urandom_range(0, 19) < 17) ? IDX_BITS'($urandom_range(0, 7))
                                                       : IDX_BITS'($urandom_range(0, 255));
            endcase
            push_read(sel, idx);
        end
    endtask

    task automatic push_noise();
        t_align_item it;
        begin
            it = t_align_item'(ITEM_BITS'($urandom));
            pending_items = {pending_items, it};
        end
    endtask

    task automatic push_sequence();
        int n;
        int len;
        int i;
        int j;
        begin
            n = $urandom_range(2, 10);
            for (i = 0; i < n; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: push_column(rand_symbol(), rand_symbol(), 1'b0);
                    4, 5: begin
                        len = $urandom_range(1, 5);
                        for (j = 0; j < len; j++) push_column(rand_symbol(), SYM_GAP, 1'b0);
                    end
                    6, 7: begin
                        len = $urandom_range(1, 5);
                        for (j = 0; j < len; j++) push_column(SYM_GAP, rand_symbol(), 1'b0);
                    end
                    8: push_column(SYM_GAP, SYM_GAP, 1'b0);
                    default: push_random_read();
                endcase
            end
            push_column($urandom_range(0, 2) == 0 ? SYM_GAP : rand_symbol(),
                        $urandom_range(0, 2) == 0 ? SYM_GAP : rand_symbol(), 1'b1);
            if ($urandom_range(0, 1) == 1) push_random_read();
        end
    endtask

    task automatic push_long_run(input bit is_del);
        int len;
        int i;
        t_table_sel sel;
        begin
            len = $urandom_range(250, 300);
            sel = is_del ? TBL_DEL : TBL_INS;
            for (i = 0; i < len; i++) begin
                if (is_del) push_column(rand_symbol(), SYM_GAP, 1'b0);
                else push_column(SYM_GAP, rand_symbol(), 1'b0);
                if ($urandom_range(0, 39) == 0) push_random_read();
            end
            push_column(3'($urandom_range(0, 3)), 3'($urandom_range(0, 3)), 1'b0);
            push_read(sel, 8'd255);
            push_read(sel, 8'd254);
            push_read(TBL_TOT, is_del ? TOT_DEL : TOT_INS);
        end
    endtask

    // Driver: hold an item until accepted, predict on acceptance, then advance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                update_tallies(cur_item);
                items_sent++;
            end
            if (i_in_valid && !o_in_ready) begin
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0 && idling_allowed()
                         && $urandom_range(0, 99) < 15) begin
                gap_left = $urandom_range(0, 2);
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                cur_item = pending_items.pop_front();
                i_mode         <= cur_item.mode;
                i_parent_code  <= cur_item.par;
                i_child_code   <= cur_item.chi;
                i_last_column  <= cur_item.last;
                i_table_select <= cur_item.sel;
                i_read_index   <= cur_item.idx;
                i_in_valid     <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted count with the oldest prediction.
    always @(posedge i_clk) begin
        logic [OUT_BITS-1:0] exp_val;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_counts.size() == 0) begin
                    report_mismatch("unexpected count", '0, o_count_value);
                end else begin
                    exp_val = pending_counts.pop_front();
                    if (o_count_value !== exp_val)
                        report_mismatch("count_value", exp_val, o_count_value);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 99) < 15) begin
                stall_left = $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        bit long_del_done;
        bit long_ins_done;
        int pick;

        ins_run   = '0;
        del_run   = '0;
        ins_total = '0;
        del_total = '0;
        for (int k = 0; k < DEF_HIST_BINS; k++) begin
            ins_hist[k] = '0;
            del_hist[k] = '0;
        end
        for (int k = 0; k < SUB_ENTRIES; k++) sub_counts[k] = '0;
        for (int k = 0; k < BASE_COUNT; k++) base_totals[k] = '0;

        push_read(TBL_TOT, TOT_INS);
        push_column(SYM_A, SYM_A, 1'b0);
        push_column(SYM_T, SYM_G, 1'b0);
        push_column(SYM_A, SYM_GAP, 1'b0);
        push_column(SYM_C, SYM_GAP, 1'b0);
        push_column(SYM_G, SYM_GAP, 1'b0);
        push_column(SYM_GAP, SYM_T, 1'b0);
        push_column(SYM_GAP, SYM_C, 1'b0);
        push_column(SYM_STAR, SYM_A, 1'b0);
        push_column(SYM_SPARE, SYM_G, 1'b0);
        push_column(SYM_OTHER, SYM_OTHER, 1'b0);
        push_column(SYM_GAP, SYM_GAP, 1'b0);
        push_column(SYM_T, SYM_GAP, 1'b0);
        push_column(SYM_GAP, SYM_GAP, 1'b0);
        push_column(SYM_T, SYM_GAP, 1'b1);
        push_column(SYM_C, SYM_C, 1'b0);
        push_read(TBL_INS, 8'd2);
        push_read(TBL_DEL, 8'd3);
        push_read(TBL_SUB, 8'd0);
        push_read(TBL_SUB, {4'd0, SYM_T[1:0], SYM_G[1:0]});
        push_read(TBL_TOT, TOT_DEL);
        push_read(TBL_TOT, TOT_BASE_END - 8'd1);
        push_read(TBL_TOT, TOT_BASE_END);
        push_read(TBL_SUB, 8'd200);
        push_read(TBL_INS, 8'd255);

        long_del_done = 1'b0;
        long_ins_done = 1'b0;
        while (pending_items.size() < ITEM_TARGET) begin
            if (!long_del_done && pending_items.size() > 450) begin
                push_long_run(1'b1);
                long_del_done = 1'b1;
            end else if (!long_ins_done && pending_items.size() > 900) begin
                push_long_run(1'b0);
                long_ins_done = 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 60) push_sequence();
                else if (pick < 85) push_random_read();
                else push_noise();
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid) @(negedge i_clk);
        while (pending_counts.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== indel_substitution_counter.f =====
+incdir+rtl
rtl/isc_pkg.sv
rtl/isc_ram.sv
rtl/isc_hist_bank.sv
rtl/indel_substitution_counter.sv
tb/sv/tb_top.sv
